/* rtl/core/tdcrd_pkg.sv */
// tdc readout word decoder: shared types, word codes and field widths
// no dependencies; imported by every module of the decoder
`default_nettype none

package tdcrd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned PAY_W    = 24;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned BOARD_W  = 5;
    localparam int unsigned TDC_W    = 2;
    localparam int unsigned CHAN_W   = 5;
    localparam int unsigned TIME_W   = 19;
    localparam int unsigned FLAT_W   = 13;
    localparam int unsigned ID_W     = 12;
    localparam int unsigned GROUP_W  = 3;
    localparam int unsigned KIND_W   = 4;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 160;
    localparam int unsigned M_USER_W = 5;

    localparam logic [TYPE_W-1:0] TYPE_EVT_HDR = 8'h1F;
    localparam logic [TYPE_W-1:0] TYPE_EVT_TRL = 8'h3F;
    localparam logic [TYPE_W-1:0] TYPE_ERROR   = 8'hDF;
    localparam logic [TYPE_W-1:0] TYPE_DEBUG   = 8'hFF;

    localparam logic [GROUP_W-1:0] GRP_GRP_HDR = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_GRP_TRL = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_TDC_HDR = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_TDC_TRL = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_MEAS    = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        K_EVT_HDR  = 4'd0,
        K_EVT_TRL  = 4'd1,
        K_ERROR    = 4'd2,
        K_DEBUG    = 4'd3,
        K_GRP_HDR  = 4'd4,
        K_GRP_TRL  = 4'd5,
        K_TDC_HDR  = 4'd6,
        K_TDC_TRL  = 4'd7,
        K_HIT      = 4'd8,
        K_HIT_DROP = 4'd9,
        K_IGNORED  = 4'd10
    } t_kind;

    // decoded fields plus next tracking state for one item
    typedef struct packed {
        t_kind               kind;
        logic                missing;
        logic [PAY_W-1:0]    daq;
        logic [TDC_W-1:0]    tdc;
        logic [CHAN_W-1:0]   chan;
        logic [TIME_W-1:0]   rtime;
        logic [FLAT_W-1:0]   flat;
        logic [ID_W-1:0]     evid;
        logic [ID_W-1:0]     bunch;
        logic                evt_inc;
        logic                hit_inc;
        logic                in_event;
        logic                board_valid;
        logic [BOARD_W-1:0]  board;
    } t_dec;

    // tracking state fed back to the decoder
    typedef struct packed {
        logic                in_event;
        logic                board_valid;
        logic [BOARD_W-1:0]  board;
    } t_track;

endpackage

`default_nettype wire

/* rtl/core/tdc_readout_word_decoder_core.sv */
// tdc readout word decoder: top level with crate register and stream ports
// uses tdcrd_pkg, tdcrd_in_reg, tdcrd_classify and tdcrd_tracker
//
// channel   dir   width  contents
// s stream  in    32     raw readout word, halves swapped
// m stream  out  160/5   decoded word fields and counters, kind and flags
// cfg       in    1      crate index, written on i_cfg_we
//
// one item per cycle sustained unless the m stream stalls; an accepted input goes
// through the input register, then classify and counters into the result register
// synchronous active-low reset clears tracking state and counters, crate = 1
// a stalled result holds; the input register still takes one more item
`default_nettype none

module tdc_readout_word_decoder_core #(
    parameter int unsigned BOARDS_PER_CRATE = 19,
    parameter int unsigned TDCS_PER_BOARD   = 4,
    parameter int unsigned CHANNELS_PER_TDC = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // raw_word[31:0]
    input  wire logic [tdcrd_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // event_count[31:0], daq_event_number[55:32], board_id[60:56], tdc_id[62:61],
    // channel_id[67:63], raw_time[86:68], flat_channel[99:87], evt_tag[111:100],
    // bx_tag[123:112], hit_count[155:124], zero[159:156]
    output logic [tdcrd_pkg::M_DATA_W-1:0]      o_m_tdata,
    // word_kind[3:0], missing_header[4]
    output logic [tdcrd_pkg::M_USER_W-1:0]      o_m_tuser
);
    import tdcrd_pkg::*;

    logic              r_crate;
    logic              in_valid;
    logic [WORD_W-1:0] in_word;
    logic              take;
    t_track            track;
    t_dec              dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crate <= 1'b1;
        end else if (i_cfg_we) begin
            r_crate <= i_cfg_wdata;
        end
    end

    tdcrd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_take  (take),
        .o_valid (in_valid),
        .o_data  (in_word)
    );

    tdcrd_classify #(
        .BOARDS_PER_CRATE (BOARDS_PER_CRATE),
        .TDCS_PER_BOARD   (TDCS_PER_BOARD),
        .CHANNELS_PER_TDC (CHANNELS_PER_TDC)
    ) u_classify (
        .i_raw   (in_word),
        .i_crate (r_crate),
        .i_track (track),
        .o_dec   (dec)
    );

    tdcrd_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_dec      (dec),
        .o_take     (take),
        .o_track    (track),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/tdcrd_in_reg.sv */
// tdc readout word decoder: input register for the slave stream
// uses tdcrd_pkg for the word width
`default_nettype none

module tdcrd_in_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tdcrd_pkg::WORD_W-1:0]  i_data,
    input  wire logic                          i_take,
    output logic                               o_valid,
    output logic [tdcrd_pkg::WORD_W-1:0]       o_data
);
    import tdcrd_pkg::*;

    logic              r_valid;
    logic [WORD_W-1:0] r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tdcrd_classify.sv */
// tdc readout word decoder: half swap, word classification and field extraction
// uses tdcrd_pkg types and codes; pure combinational logic
`default_nettype none

module tdcrd_classify #(
    parameter int unsigned BOARDS_PER_CRATE = 19,
    parameter int unsigned TDCS_PER_BOARD   = 4,
    parameter int unsigned CHANNELS_PER_TDC = 32
) (
    input  wire logic [tdcrd_pkg::WORD_W-1:0] i_raw,
    input  wire logic                         i_crate,
    input  wire tdcrd_pkg::t_track            i_track,
    output tdcrd_pkg::t_dec                   o_dec
);
    import tdcrd_pkg::*;

    logic [WORD_W-1:0]  word;
    logic [TYPE_W-1:0]  wtype;
    logic [PAY_W-1:0]   payload;
    logic [GROUP_W-1:0] group;
    logic [31:0]        flat_full;

    assign word    = {i_raw[15:0], i_raw[31:16]};
    assign wtype   = word[WORD_W-1 -: TYPE_W];
    assign payload = word[PAY_W-1:0];
    assign group   = wtype[TYPE_W-1 -: GROUP_W];

    assign flat_full = ((32'(i_crate) * BOARDS_PER_CRATE + 32'(i_track.board))
                        * TDCS_PER_BOARD + 32'(wtype[TDC_W-1:0]))
                       * CHANNELS_PER_TDC + 32'(payload[PAY_W-1 -: CHAN_W]);

    always_comb begin
        o_dec             = '0;
        o_dec.kind        = K_IGNORED;
        o_dec.in_event    = i_track.in_event;
        o_dec.board_valid = i_track.board_valid;
        o_dec.board       = i_track.board;
        unique case (wtype)
            TYPE_EVT_HDR: begin
                o_dec.kind        = K_EVT_HDR;
                o_dec.in_event    = 1'b1;
                o_dec.board_valid = 1'b0;
                o_dec.evt_inc     = 1'b1;
                o_dec.daq         = payload;
            end
            TYPE_EVT_TRL: begin
                o_dec.kind        = K_EVT_TRL;
                o_dec.in_event    = 1'b0;
                o_dec.board_valid = 1'b0;
            end
            TYPE_ERROR: begin
                o_dec.kind = K_ERROR;
            end
            TYPE_DEBUG: begin
                o_dec.kind = K_DEBUG;
            end
            default: begin
                o_dec.missing  = !i_track.in_event;
                o_dec.evt_inc  = !i_track.in_event;
                o_dec.in_event = 1'b1;
                unique case (group) inside
                    GRP_GRP_HDR, GRP_GRP_TRL, GRP_TDC_HDR, GRP_TDC_TRL: begin
                        o_dec.evid  = payload[PAY_W-1 -: ID_W];
                        o_dec.bunch = payload[ID_W-1:0];
                        o_dec.kind  = t_kind'(KIND_W'(K_GRP_HDR) + KIND_W'(group));
                        if (group == GRP_GRP_HDR) begin
                            o_dec.board       = wtype[BOARD_W-1:0];
                            o_dec.board_valid = 1'b1;
                        end else if (group == GRP_GRP_TRL) begin
                            o_dec.board_valid = 1'b0;
                        end else begin
                            o_dec.tdc = wtype[TDC_W-1:0];
                        end
                    end
                    GRP_MEAS: begin
                        if (i_track.board_valid) begin
                            o_dec.kind    = K_HIT;
                            o_dec.tdc     = wtype[TDC_W-1:0];
                            o_dec.chan    = payload[PAY_W-1 -: CHAN_W];
                            o_dec.rtime   = payload[TIME_W-1:0];
                            o_dec.flat    = flat_full[FLAT_W-1:0];
                            o_dec.hit_inc = 1'b1;
                        end else begin
                            o_dec.kind = K_HIT_DROP;
                        end
                    end
                    default: begin
                        o_dec.kind = K_IGNORED;
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/tdcrd_tracker.sv */
// tdc readout word decoder: event/board tracking, counters and result register
// uses tdcrd_pkg types; takes decoded items from tdcrd_classify
`default_nettype none

module tdcrd_tracker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire tdcrd_pkg::t_dec                 i_dec,
    output logic                                 o_take,
    output tdcrd_pkg::t_track                    o_track,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [tdcrd_pkg::M_DATA_W-1:0]       o_m_tdata,
    output logic [tdcrd_pkg::M_USER_W-1:0]       o_m_tuser
);
    import tdcrd_pkg::*;

    logic               r_in_event;
    logic               r_board_valid;
    logic [BOARD_W-1:0] r_board;
    logic [CNT_W-1:0]   r_event_cnt;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic               r_out_valid;
    logic [M_DATA_W-1:0] r_tdata;
    logic [M_USER_W-1:0] r_tuser;

    logic [CNT_W-1:0]   n_event_cnt;
    logic [CNT_W-1:0]   n_hit_cnt;
    logic [BOARD_W-1:0] board_out;

    assign o_take = i_valid && (!r_out_valid || i_m_tready);

    assign o_track.in_event    = r_in_event;
    assign o_track.board_valid = r_board_valid;
    assign o_track.board       = r_board;

    assign n_event_cnt = r_event_cnt + CNT_W'(i_dec.evt_inc);
    assign n_hit_cnt   = r_hit_cnt + CNT_W'(i_dec.hit_inc);
    assign board_out   = i_dec.board_valid ? i_dec.board : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_event    <= 1'b0;
            r_board_valid <= 1'b0;
            r_board       <= '0;
            r_event_cnt   <= '0;
            r_hit_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_take) begin
                r_in_event    <= i_dec.in_event;
                r_board_valid <= i_dec.board_valid;
                r_board       <= i_dec.board;
                r_event_cnt   <= n_event_cnt;
                r_hit_cnt     <= n_hit_cnt;
                r_out_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_tdata <= {4'b0000, n_hit_cnt, i_dec.bunch, i_dec.evid, i_dec.flat,
                        i_dec.rtime, i_dec.chan, i_dec.tdc, board_out,
                        i_dec.daq, n_event_cnt};
            r_tuser <= {i_dec.missing, i_dec.kind};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// testbench for the tdc readout word decoder: a directed table, then random readout streams
// results are checked against a decoder model kept in the bench; needs tdcrd_pkg and the core
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdcrd_pkg::*;

    localparam int unsigned BOARDS_PER_CRATE = 19;
    localparam int unsigned TDCS_PER_BOARD   = 4;
    localparam int unsigned CHANNELS_PER_TDC = 32;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          ITEMS_PER_PHASE  = 150;
    localparam int          N_KINDS          = 11;

    typedef struct packed {
        t_kind               kind;
        logic                missing;
        logic [CNT_W-1:0]    evts;
        logic [PAY_W-1:0]    daq;
        logic [BOARD_W-1:0]  board;
        logic [TDC_W-1:0]    tdc;
        logic [CHAN_W-1:0]   chan;
        logic [TIME_W-1:0]   rtime;
        logic [FLAT_W-1:0]   flat;
        logic [ID_W-1:0]     evid;
        logic [ID_W-1:0]     bunch;
        logic [CNT_W-1:0]    hits;
    } t_decoded;

    // one row of the directed table; the word is given with its halves in order
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic                typed;
        t_kind               kind;
        logic                missing;
        logic [CNT_W-1:0]    evts;
    } t_dir_row;

    localparam int N_DIR = 24;
    localparam t_dir_row DIRECTED [N_DIR] = '{
        '{32'hFF_FFFFFF, 1'b1, K_DEBUG,    1'b0, 32'd0},
        '{32'h00_000000, 1'b1, K_GRP_HDR,  1'b1, 32'd1},
        '{32'hDF_123456, 1'b1, K_ERROR,    1'b0, 32'd1},
        '{32'h3F_FFFFFF, 1'b1, K_EVT_TRL,  1'b0, 32'd1},
        '{32'h80_5A5A5A, 1'b1, K_HIT_DROP, 1'b1, 32'd2},
        '{32'h1F_FFFFFF, 1'b1, K_EVT_HDR,  1'b0, 32'd3},
        '{32'h1E_FFFFFF, 1'b0, K_GRP_HDR,  1'b0, 32'd0},
        '{32'h43_000000, 1'b0, K_TDC_HDR,  1'b0, 32'd0},
        '{32'h83_FFFFFF, 1'b0, K_HIT,      1'b0, 32'd0},
        '{32'h9C_000000, 1'b0, K_HIT,      1'b0, 32'd0},
        '{32'hA0_FFFFFF, 1'b1, K_IGNORED,  1'b0, 32'd3},
        '{32'hC5_0F0F0F, 1'b1, K_IGNORED,  1'b0, 32'd3},
        '{32'hFE_FFFFFF, 1'b1, K_IGNORED,  1'b0, 32'd3},
        '{32'hFF_000000, 1'b1, K_DEBUG,    1'b0, 32'd3},
        '{32'h62_ABCDEF, 1'b0, K_TDC_TRL,  1'b0, 32'd0},
        '{32'h20_000000, 1'b0, K_GRP_TRL,  1'b0, 32'd0},
        '{32'h81_123456, 1'b1, K_HIT_DROP, 1'b0, 32'd3},
        '{32'h3F_000000, 1'b1, K_EVT_TRL,  1'b0, 32'd3},
        '{32'hE0_000000, 1'b1, K_IGNORED,  1'b1, 32'd4},
        '{32'h1F_000000, 1'b1, K_EVT_HDR,  1'b0, 32'd5},
        '{32'h00_000000, 1'b0, K_GRP_HDR,  1'b0, 32'd0},
        '{32'h80_000000, 1'b0, K_HIT,      1'b0, 32'd0},
        '{32'h3F_000000, 1'b1, K_EVT_TRL,  1'b0, 32'd5},
        '{32'h5F_FFFFFF, 1'b1, K_TDC_HDR,  1'b1, 32'd6}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic [M_USER_W-1:0]   o_m_tuser;

    // decoder model state
    logic                  crate_reg   = 1'b1;
    logic                  in_event    = 1'b0;
    logic                  board_valid = 1'b0;
    logic [BOARD_W-1:0]    board_reg   = '0;
    logic [CNT_W-1:0]      event_cnt   = '0;
    logic [CNT_W-1:0]      hit_cnt     = '0;
    logic [CNT_W-1:0]      trailer_cnt = '0;
    logic [CNT_W-1:0]      error_cnt   = '0;
    logic [CNT_W-1:0]      debug_cnt   = '0;

    t_decoded              decoded_q[$];
    t_dir_row              typed_q[$];
    int                    errors      = 0;
    int                    sent        = 0;
    int                    checked     = 0;
    int                    cycles      = 0;
    int                    src_idle_pct = 30;
    int                    snk_idle_pct = 70;
    int                    kind_seen [N_KINDS] = '{default: 0};

    tdc_readout_word_decoder_core #(
        .BOARDS_PER_CRATE (BOARDS_PER_CRATE),
        .TDCS_PER_BOARD   (TDCS_PER_BOARD),
        .CHANNELS_PER_TDC (CHANNELS_PER_TDC)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] x);
        return {x[15:0], x[31:16]};
    endfunction

    function automatic logic [PAY_W-1:0] rnd24();
        return PAY_W'($urandom);
    endfunction

    function automatic t_decoded decode_word(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0]  w;
        logic [TYPE_W-1:0]  ty;
        logic [PAY_W-1:0]   pay;
        logic [GROUP_W-1:0] grp;
        int unsigned        flat32;
        t_decoded           r;
        w   = swap_halves(raw);
        ty  = w[31:24];
        pay = w[23:0];
        grp = ty[7:5];
        r = '0;
        r.kind = K_IGNORED;
        case (ty)
            TYPE_EVT_HDR: begin
                r.kind = K_EVT_HDR;
                in_event = 1'b1;
                board_valid = 1'b0;
                event_cnt = event_cnt + 1;
                r.daq = pay;
            end
            TYPE_EVT_TRL: begin
                r.kind = K_EVT_TRL;
                in_event = 1'b0;
                board_valid = 1'b0;
                trailer_cnt = trailer_cnt + 1;
            end
            TYPE_ERROR: begin
                r.kind = K_ERROR;
                error_cnt = error_cnt + 1;
            end
            TYPE_DEBUG: begin
                r.kind = K_DEBUG;
                debug_cnt = debug_cnt + 1;
            end
            default: begin
                if (!in_event) begin
                    r.missing = 1'b1;
                    event_cnt = event_cnt + 1;
                end
                if (grp <= GRP_TDC_TRL) begin
                    r.evid  = pay[23:12];
                    r.bunch = pay[11:0];
                end
                case (grp)
                    GRP_GRP_HDR: begin
                        r.kind = K_GRP_HDR;
                        board_reg = ty[4:0];
                        board_valid = 1'b1;
                    end
                    GRP_GRP_TRL: begin
                        r.kind = K_GRP_TRL;
                        board_valid = 1'b0;
                    end
                    GRP_TDC_HDR: begin
                        r.kind = K_TDC_HDR;
                        r.tdc = ty[1:0];
                    end
                    GRP_TDC_TRL: begin
                        r.kind = K_TDC_TRL;
                        r.tdc = ty[1:0];
                    end
                    GRP_MEAS: begin
                        if (board_valid) begin
                            r.kind  = K_HIT;
                            r.tdc   = ty[1:0];
                            r.chan  = pay[23:19];
                            r.rtime = pay[18:0];
                            flat32 = ((32'(crate_reg) * BOARDS_PER_CRATE + 32'(board_reg))
                                      * TDCS_PER_BOARD + 32'(r.tdc)) * CHANNELS_PER_TDC
                                     + 32'(r.chan);
                            r.flat = flat32[FLAT_W-1:0];
                            hit_cnt = hit_cnt + 1;
                        end else begin
                            r.kind = K_HIT_DROP;
                        end
                    end
                    default: r.kind = K_IGNORED;
                endcase
                in_event = 1'b1;
            end
        endcase
        r.evts  = event_cnt;
        r.board = board_valid ? board_reg : '0;
        r.hits  = hit_cnt;
        return r;
    endfunction

    task automatic report_field(input string what, input logic [CNT_W-1:0] got,
                                input logic [CNT_W-1:0] want);
        if (got !== want) begin
            errors++;
            if (errors <= 40)
                $display("mismatch %s at cycle %0d: got %0h want %0h", what, cycles, got, want);
        end
    endtask

    task automatic check_result();
        t_decoded want;
        if (decoded_q.size() == 0) begin
            report_field("result with no item pending", 32'd1, 32'd0);
            return;
        end
        want = decoded_q.pop_front();
        checked++;
        kind_seen[int'(want.kind)]++;
        report_field("word_kind",        o_m_tuser[3:0],      want.kind);
        report_field("missing_header",   o_m_tuser[4],        want.missing);
        report_field("event_count",      o_m_tdata[31:0],     want.evts);
        report_field("daq_event_number", o_m_tdata[55:32],    want.daq);
        report_field("board_id",         o_m_tdata[60:56],    want.board);
        report_field("tdc_id",           o_m_tdata[62:61],    want.tdc);
        report_field("channel_id",       o_m_tdata[67:63],    want.chan);
        report_field("raw_time",         o_m_tdata[86:68],    want.rtime);
        report_field("flat_channel",     o_m_tdata[99:87],    want.flat);
        report_field("evt_tag",          o_m_tdata[111:100],  want.evid);
        report_field("bx_tag",           o_m_tdata[123:112],  want.bunch);
        report_field("hit_count",        o_m_tdata[155:124],  want.hits);
        report_field("tdata pad",        o_m_tdata[159:156],  32'd0);
    endtask

    always @(posedge i_clk) begin
        t_decoded d;
        t_dir_row t;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && o_s_tready) begin
                d = decode_word(i_s_tdata);
                t = typed_q.pop_front();
                if (t.typed) begin
                    d.kind    = t.kind;
                    d.missing = t.missing;
                    d.evts    = t.evts;
                end
                decoded_q.push_back(d);
            end
        end
    end

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, decoded_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input t_dir_row hand);
        typed_q.push_back(hand);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= swap_halves(w);
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_crate(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        crate_reg = v;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(3))
                0: send_word($urandom, '0);
                1: send_word({($urandom_range(1) ? TYPE_ERROR : TYPE_DEBUG), rnd24()}, '0);
                2: send_word({3'($urandom_range(5, 7)), 5'($urandom), rnd24()}, '0);
                default: send_word({3'($urandom_range(0, 4)), 5'($urandom), rnd24()}, '0);
            endcase
        end
    endtask

    // header, groups of tdc blocks with hits, trailer; headers and trailers sometimes left out
    task automatic send_event();
        int                 ngrp;
        int                 ntdc;
        int                 nhit;
        logic [BOARD_W-1:0] board;
        logic [TDC_W-1:0]   tdc;
        if ($urandom_range(9) != 0)
            send_word({TYPE_EVT_HDR, rnd24()}, '0);
        ngrp = $urandom_range(1, 3);
        repeat (ngrp) begin
            board = ($urandom_range(7) == 0) ? 5'($urandom_range(19, 30))
                                             : 5'($urandom_range(0, 18));
            send_word({GRP_GRP_HDR, board, rnd24()}, '0);
            ntdc = $urandom_range(1, 2);
            repeat (ntdc) begin
                tdc = 2'($urandom);
                send_word({GRP_TDC_HDR, 3'($urandom), tdc, rnd24()}, '0);
                nhit = $urandom_range(0, 5);
                repeat (nhit) begin
                    if ($urandom_range(19) == 0)
                        send_word({($urandom_range(1) ? TYPE_ERROR : TYPE_DEBUG), rnd24()}, '0);
                    send_word({GRP_MEAS, 3'($urandom), tdc, rnd24()}, '0);
                end
                send_word({GRP_TDC_TRL, 3'($urandom), tdc, rnd24()}, '0);
            end
            send_word({GRP_GRP_TRL, 5'($urandom_range(0, 30)), rnd24()}, '0);
            if ($urandom_range(9) == 0)
                send_word({GRP_MEAS, 5'($urandom), rnd24()}, '0);
        end
        if ($urandom_range(9) != 0)
            send_word({TYPE_EVT_TRL, rnd24()}, '0);
    endtask

    task automatic run_random(input int n);
        int target;
        target = sent + n;
        while (sent < target) begin
            if ($urandom_range(99) < 15)
                send_noise();
            else
                send_event();
        end
    endtask

    initial begin
        int kinds;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 30;
        snk_idle_pct = 70;
        for (int i = 0; i < N_DIR; i++)
            send_word(DIRECTED[i].word, DIRECTED[i]);
        drain();
        write_crate(1'b0);
        run_random(ITEMS_PER_PHASE);
        drain();

        src_idle_pct = 70;
        snk_idle_pct = 30;
        write_crate(1'b1);
        run_random(ITEMS_PER_PHASE);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_crate(1'b0);
        run_random(ITEMS_PER_PHASE);
        drain();

        if (decoded_q.size() != 0)
            report_field("items left without result", decoded_q.size(), 32'd0);
        kinds = 0;
        for (int k = 0; k < N_KINDS; k++)
            if (kind_seen[k] != 0)
                kinds++;
        $display("%0d words in, %0d results, %0d hits, %0d trailers, %0d error, %0d debug, %0d of %0d kinds",
                 sent, checked, hit_cnt, trailer_cnt, error_cnt, debug_cnt, kinds, N_KINDS);
        $display("crate index 1, 0, 1, 0; idling 30/70, 70/30 and none; %0d mismatches", errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
